// ----- rtl/sequence_store_positional_insert_macros.svh -----
// Assertion macros shared by the sequence store RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef SEQUENCE_STORE_POSITIONAL_INSERT_MACROS_SVH
`define SEQUENCE_STORE_POSITIONAL_INSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ssp_pkg.sv -----
// Shared types and codes for the sequence store with positional insert.
// No dependencies.
package ssp_pkg;

  localparam int DEPTH_DEF = 32;   // default number of cells
  localparam int DATA_W    = 32;   // stored value width
  localparam int OP_W      = 3;    // operation code width
  localparam int POS_W     = 6;    // insert position width
  localparam int STAT_W    = 2;    // status width
  localparam int CNTO_W    = 6;    // reported count width
  localparam int IDX_W     = 7;    // cell index / count compare width, covers DEPTH up to 64

  localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
  localparam logic [OP_W-1:0] OP_PREPEND   = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT    = 3'd4;
  localparam logic [OP_W-1:0] OP_READ      = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  // What every cell does in a given cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,   // keep value
    CELL_INS,    // open a gap at pos and write din there
    CELL_SHL,    // take the value of the next cell toward the back
    CELL_ROT     // rotate the occupied cells one step toward the front
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   pos;    // insert index
    logic [IDX_W-1:0]   tail;   // index of the last occupied cell
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ssp_state_t;

endpackage

// ----- rtl/ssp_cell.sv -----
// One storage cell of the sequence store chain.
// Depends on ssp_pkg.
module ssp_cell
  import ssp_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] din,
  input  logic signed [DATA_W-1:0] left,   // neighbor toward the front
  input  logic signed [DATA_W-1:0] right,  // neighbor toward the back
  input  logic signed [DATA_W-1:0] head,   // value of cell 0
  output logic signed [DATA_W-1:0] q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [DATA_W-1:0] q_r;
  logic signed [DATA_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (cmd.op)
      CELL_INS: begin
        if (MY_IDX == cmd.pos) begin
          q_nxt = din;
        end else if (MY_IDX > cmd.pos) begin
          q_nxt = left;
        end
      end
      CELL_SHL: begin
        q_nxt = right;
      end
      CELL_ROT: begin
        if (MY_IDX < cmd.tail) begin
          q_nxt = right;
        end else if (MY_IDX == cmd.tail) begin
          q_nxt = head;
        end
      end
      default: begin
        q_nxt = q_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ----- rtl/sequence_store_positional_insert.sv -----
// Sequence store with positional insert: a row of DEPTH value cells plus control.
// Depends on ssp_pkg, ssp_cell and sequence_store_positional_insert_macros.svh.
//
// The store keeps up to DEPTH signed 32-bit values front to back in a row of cells,
// cell 0 being the front. Every cell moves in parallel, so for append, prepend,
// insert at a position and both pops an item is taken, the cells shift as needed
// at the same edge, and its single result is registered for the output. The next
// item is taken as soon as the output register is free or being emptied, so these
// operations sustain one item per cycle. Read-out of a non-empty store streams one
// value per cycle while the output is not stalled, rotating the occupied cells
// toward the front and tapping cell 0; after count steps the order is back where
// it started. No new item is taken during a read-out; the rate is set by that
// rotation of the cell row. The results carry the status code, the count after
// the operation and a last flag on the final result of each item. There is no
// clearing pass after reset: cells beyond the count are never reported.
module sequence_store_positional_insert
  import ssp_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_value_out,
  output logic [STAT_W-1:0]        out_status,
  output logic [CNTO_W-1:0]        out_count_out,
  output logic                     out_last
);

`include "sequence_store_positional_insert_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // control state
  ssp_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;     // read-out values still to send
  logic             out_valid_r, out_valid_nxt;

  // result payload
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;
  logic [CNT_W-1:0]         out_count_r, out_count_nxt;
  logic                     out_last_r, out_last_nxt;

  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_q [DEPTH];
  logic signed [DATA_W-1:0] tail_val;
  logic [IDX_W-1:0]         tail_idx;
  logic [IDX_W-1:0]         count_ext;
  logic                     out_free;
  logic                     fire;
  logic                     emit;
  logic                     is_full;
  logic                     is_empty;

  // Output slot frees up when empty or being taken this edge.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign fire      = in_valid && !in_stall;
  assign is_full   = (count_r == CNT_FULL);
  assign is_empty  = (count_r == '0);
  assign count_ext = IDX_W'(count_r);
  assign tail_idx  = count_ext - IDX_W'(1);

  // Tap the last occupied cell for pop from the back.
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (IDX_W'(i) == tail_idx) begin
        tail_val = cell_q[i];
      end
    end
  end

  // Next state, cell command and result.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    emit           = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    cmd.op         = CELL_HOLD;
    cmd.pos        = '0;
    cmd.tail       = tail_idx;

    case (state_r)
      ST_IDLE: begin
        if (fire) begin
          emit           = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = STAT_OK;
          out_last_nxt   = 1'b1;
          case (in_operation)
            OP_APPEND, OP_PREPEND, OP_INSERT: begin
              if (is_full) begin
                out_status_nxt = STAT_FULL;
              end else if ((in_operation == OP_INSERT) && !is_empty &&
                           (IDX_W'(in_position) > count_ext)) begin
                out_status_nxt = STAT_RANGE;
              end else begin
                cmd.op = CELL_INS;
                if (in_operation == OP_APPEND) begin
                  cmd.pos = count_ext;
                end else if ((in_operation == OP_PREPEND) || is_empty) begin
                  cmd.pos = '0;
                end else begin
                  cmd.pos = IDX_W'(in_position);
                end
                count_nxt = count_r + CNT_ONE;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_value_nxt = tail_val;
                count_nxt     = count_r - CNT_ONE;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_value_nxt = cell_q[0];
                cmd.op        = CELL_SHL;
                count_nxt     = count_r - CNT_ONE;
              end
            end
            OP_READ: begin
              if (is_empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                // send the front value now, rotate, stream the rest
                out_value_nxt = cell_q[0];
                cmd.op        = CELL_ROT;
                out_last_nxt  = (count_r == CNT_ONE);
                rem_nxt       = count_r - CNT_ONE;
                if (count_r != CNT_ONE) begin
                  state_nxt = ST_READ;
                end
              end
            end
            default: begin
              out_status_nxt = STAT_OK;
            end
          endcase
          out_count_nxt = count_nxt;
        end
      end
      ST_READ: begin
        if (out_free) begin
          emit           = 1'b1;
          out_value_nxt  = cell_q[0];
          out_status_nxt = STAT_OK;
          out_count_nxt  = count_r;
          out_last_nxt   = (rem_r == CNT_ONE);
          cmd.op         = CELL_ROT;
          rem_nxt        = rem_r - CNT_ONE;
          if (rem_r == CNT_ONE) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hold a stalled result, drop a taken one
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  // The cell row: front neighbor of cell 0 is the incoming value, the back cell
  // sees itself as its back neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;

    if (g == 0) begin : g_front
      assign left_v = in_value;
    end else begin : g_mid_l
      assign left_v = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_back
      assign right_v = cell_q[g];
    end else begin : g_mid_r
      assign right_v = cell_q[g+1];
    end

    ssp_cell #(
      .IDX (g)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .din   (in_value),
      .left  (left_v),
      .right (right_v),
      .head  (cell_q[0]),
      .q     (cell_q[g])
    );
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;
  assign out_count_out = CNTO_W'(out_count_r);
  assign out_last      = out_last_r;

  `SSP_ASSERT(a_count_bound, (count_r <= CNT_FULL), "fill count exceeds depth")
  `SSP_ASSERT(a_read_stalls_input, ((state_r == ST_READ) |-> in_stall),
    "input transfer possible during read-out")
  `SSP_ASSERT(a_read_rem, ((state_r == ST_READ) |-> ((rem_r != '0) && (rem_r < count_r))),
    "read-out remainder out of range")
  `SSP_ASSERT(a_pop_empty, ((fire && is_empty && ((in_operation == OP_POP_BACK) ||
    (in_operation == OP_POP_FRONT))) |=> (out_valid_r && (out_status_r == STAT_EMPTY)
    && (count_r == '0))), "pop from empty store not flagged")
  `SSP_ASSERT(a_full_drop, ((fire && is_full && ((in_operation == OP_APPEND) ||
    (in_operation == OP_PREPEND) || (in_operation == OP_INSERT))) |=>
    ((count_r == $past(count_r)) && (out_status_r == STAT_FULL))),
    "push into full store changed the count")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for sequence_store_positional_insert.
// Depends on ssp_pkg and the RTL of the block; drives random and directed transfers
// against a shadow store that predicts every result.
module tb_top;
  import ssp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH  = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 410;
  localparam int QUIET_LIMIT  = 2000;   // cycles without any transfer before giving up
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off that backs up the block
  localparam int HOLD_AFTER   = 120;    // input transfers taken before the hold-off starts
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 50;

  // Codes the block treats as no-ops.
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
  } store_cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [STAT_W-1:0]        status;
    logic [CNTO_W-1:0]        count;
    logic                     last;
  } store_result_t;

  typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_operation = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_value_out;
  logic [STAT_W-1:0]        out_status;
  logic [CNTO_W-1:0]        out_count_out;
  logic                     out_last;

  sequence_store_positional_insert #(
    .DEPTH(STORE_DEPTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_position  (in_position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value_out(out_value_out),
    .out_status   (out_status),
    .out_count_out(out_count_out),
    .out_last     (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Shadow store: the values the block should hold, front to back, and the
  // results each accepted command still owes.
  // -------------------------------------------------------------------------
  logic signed [DATA_W-1:0] shadow_cells [STORE_DEPTH];
  int                       shadow_fill = 0;
  store_result_t            due_results [$];

  store_cmd_t cmd_backlog [$];   // commands not yet offered to the block
  int         gen_fill = 0;      // fill level the generator expects, to aim positions
  int         total_cmds = 0;
  int         cmds_taken = 0;
  int         err_count = 0;

  task automatic flag_error(input string msg);
    if (err_count < MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  function automatic void owe_result(input logic signed [DATA_W-1:0] v,
                                     input logic [STAT_W-1:0] st, input logic lst);
    store_result_t r;
    r.value  = v;
    r.status = st;
    r.count  = CNTO_W'(shadow_fill);
    r.last   = lst;
    due_results.insert(due_results.size(), r);
  endfunction

  // Apply one accepted command to the shadow store and queue what it owes.
  function automatic void shadow_store_apply(input logic [OP_W-1:0] op,
                                             input logic signed [DATA_W-1:0] val,
                                             input logic [POS_W-1:0] pos);
    int slot;
    int i;
    logic signed [DATA_W-1:0] head;
    case (op)
      OP_APPEND, OP_PREPEND, OP_INSERT: begin
        // An empty store takes an insert at the front whatever the position.
        if (op == OP_APPEND) slot = shadow_fill;
        else if (op == OP_PREPEND || shadow_fill == 0) slot = 0;
        else slot = int'(pos);
        // Full is checked before the position.
        if (shadow_fill >= STORE_DEPTH) owe_result('0, STAT_FULL, 1'b1);
        else if (slot > shadow_fill) owe_result('0, STAT_RANGE, 1'b1);
        else begin
          for (i = shadow_fill; i > slot; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[slot] = val;
          shadow_fill++;
          owe_result('0, STAT_OK, 1'b1);
        end
      end
      OP_POP_BACK: begin
        if (shadow_fill == 0) owe_result('0, STAT_EMPTY, 1'b1);
        else begin
          shadow_fill--;
          owe_result(shadow_cells[shadow_fill], STAT_OK, 1'b1);
        end
      end
      OP_POP_FRONT: begin
        if (shadow_fill == 0) owe_result('0, STAT_EMPTY, 1'b1);
        else begin
          head = shadow_cells[0];
          for (i = 1; i < shadow_fill; i++) shadow_cells[i-1] = shadow_cells[i];
          shadow_fill--;
          owe_result(head, STAT_OK, 1'b1);
        end
      end
      OP_READ: begin
        if (shadow_fill == 0) owe_result('0, STAT_EMPTY, 1'b1);
        else begin
          for (i = 0; i < shadow_fill; i++)
            owe_result(shadow_cells[i], STAT_OK, (i == shadow_fill - 1));
        end
      end
      default: owe_result('0, STAT_OK, 1'b1);   // spare codes leave the store alone
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus generation
  // -------------------------------------------------------------------------
  function automatic void queue_cmd(input logic [OP_W-1:0] op,
                                    input logic signed [DATA_W-1:0] val,
                                    input logic [POS_W-1:0] pos);
    store_cmd_t c;
    c.op    = op;
    c.value = val;
    c.pos   = pos;
    cmd_backlog.insert(cmd_backlog.size(), c);
    // Track the fill level roughly so insert positions land mostly in range.
    case (op)
      OP_APPEND, OP_PREPEND: if (gen_fill < STORE_DEPTH) gen_fill++;
      OP_INSERT:
        if (gen_fill < STORE_DEPTH && (gen_fill == 0 || int'(pos) <= gen_fill)) gen_fill++;
      OP_POP_BACK, OP_POP_FRONT: if (gen_fill > 0) gen_fill--;
      default: ;
    endcase
  endfunction

  // Lean on the extremes now and then, otherwise fully random.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 32'sh8000_0000;
    if (roll < 16) return 32'sh7fff_ffff;
    if (roll < 20) return '0;
    if (roll < 24) return '1;
    return $urandom;
  endfunction

  initial begin : stimulus
    mix_t             mix;
    int               seg_len;
    int               n_random;
    int               roll;
    int               push_pct;
    int               pop_pct;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;

    // Directed: empty-store corners first.
    queue_cmd(OP_READ,      '0, '0);
    queue_cmd(OP_POP_BACK,  '1, '1);
    queue_cmd(OP_POP_FRONT, '0, '0);
    // Insert on an empty store appends even with an absurd position.
    queue_cmd(OP_INSERT,    32'sh7fff_ffff, 6'd63);
    queue_cmd(OP_APPEND,    32'sh8000_0000, '0);
    queue_cmd(OP_PREPEND,   '0, '0);
    queue_cmd(OP_INSERT,    '1, 6'd0);              // front, like a prepend
    queue_cmd(OP_INSERT,    32'sd12345, 6'd4);      // at the count, like an append
    queue_cmd(OP_INSERT,    32'sd99, 6'd6);         // one beyond the count
    queue_cmd(OP_INSERT,    32'sh5555_5555, 6'd2);  // middle
    queue_cmd(OP_INSERT,    32'shaaaa_aaaa, 6'd42); // far beyond the count
    queue_cmd(OP_READ,      '0, '0);
    queue_cmd(OP_SPARE6,    32'sh1234_5678, 6'd21);
    queue_cmd(OP_SPARE7,    '1, '1);
    queue_cmd(OP_POP_FRONT, '0, '0);
    queue_cmd(OP_POP_BACK,  '0, '0);
    queue_cmd(OP_INSERT,    -32'sd7, 6'd1);
    queue_cmd(OP_READ,      '0, '0);
    queue_cmd(OP_POP_FRONT, '0, '0);
    queue_cmd(OP_POP_BACK,  '0, '0);
    queue_cmd(OP_READ,      '0, '0);

    // Random: segments that grow, shrink or hover, so the store keeps
    // reaching both full and empty.
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      mix = mix_t'($urandom_range(0, 2));
      seg_len = $urandom_range(30, 80);
      case (mix)
        MIX_GROW:   begin push_pct = 75; pop_pct = 90; end
        MIX_SHRINK: begin push_pct = 25; pop_pct = 90; end
        default:    begin push_pct = 48; pop_pct = 90; end
      endcase
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
          case ($urandom_range(0, 2))
            0:       op = OP_APPEND;
            1:       op = OP_PREPEND;
            default: op = OP_INSERT;
          endcase
        end else if (roll < pop_pct) op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        else if (roll < 98) op = OP_READ;
        else op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
        // Mostly a legal position, sometimes anything the field can carry.
        if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(0, 63));
        else pos = POS_W'($urandom_range(0, gen_fill));
        queue_cmd(op, pick_value(), pos);
      end
      n_random += seg_len;
    end
    total_cmds = cmd_backlog.size();

    // Hold reset low at the start, then release it once.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every command to be taken and every owed result to arrive.
    while (cmds_taken < total_cmds) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    // Give a stray extra result time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Driver: offers commands in bursts separated by random gaps. A stalled
  // transfer is held unchanged until the block takes it.
  // -------------------------------------------------------------------------
  int         burst_left = 0;
  int         gap_left = 0;
  store_cmd_t next_cmd;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      // Predict from the payload the block has just taken.
      if (in_valid && !in_stall) begin
        shadow_store_apply(in_operation, in_value, in_position);
        cmds_taken <= cmds_taken + 1;
      end
      // Advance only when nothing is held waiting.
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (cmd_backlog.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          next_cmd = cmd_backlog[0];
          cmd_backlog.delete(0);
          in_valid     <= 1'b1;
          in_operation <= next_cmd.op;
          in_value     <= next_cmd.value;
          in_position  <= next_cmd.pos;
          // At the end of a burst, draw the next gap (often none) and burst length.
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver stall: switch between stall patterns every so often, and once
  // hold off for a long stretch so the block backs up and stalls its input.
  // -------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          stall_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && cmds_taken >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        hold_done <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= stall_mode_t'($urandom_range(0, 3));
          mode_left  <= $urandom_range(20, 100);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          STALL_RANDOM:   out_stall <= ($urandom_range(0, 1) == 0);
          STALL_PERIODIC: out_stall <= (stall_tick % 4 == 0);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 8);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest owed result.
  // -------------------------------------------------------------------------
  store_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        flag_error($sformatf("unexpected result value=%0d status=%0d count=%0d last=%0b",
                             out_value_out, out_status, out_count_out, out_last));
      end else begin
        want = due_results[0];
        due_results.delete(0);
        if (out_value_out !== want.value)
          flag_error($sformatf("value_out %0d, expected %0d", out_value_out, want.value));
        if (out_status !== want.status)
          flag_error($sformatf("status %0d, expected %0d", out_status, want.status));
        if (out_count_out !== want.count)
          flag_error($sformatf("count_out %0d, expected %0d", out_count_out, want.count));
        if (out_last !== want.last)
          flag_error($sformatf("last %0b, expected %0b", out_last, want.last));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves for too long.
  // -------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

// ----- sequence_store_positional_insert.f -----
+incdir+rtl
rtl/ssp_pkg.sv
rtl/ssp_cell.sv
rtl/sequence_store_positional_insert.sv
tb/tb_top.sv
